// ----- hw/rtl/lbf_pkg.sv -----
`default_nettype none

package lbf_pkg;

    localparam int TABLE_ENTRIES = 32;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int ADDR_W        = 48;
    localparam int SEG_W         = 2;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    localparam logic [SEG_W-1:0] SEG_NONE    = 2'd0;
    localparam logic [SEG_W-1:0] SEG_FIRST   = 2'd1;
    localparam logic [SEG_W-1:0] SEG_SECOND  = 2'd2;
    localparam logic [SEG_W-1:0] SEG_INVALID = 2'd3;

    typedef struct packed {
        logic [ADDR_W-1:0] src_mac;
        logic [ADDR_W-1:0] dst_mac;
        logic [SEG_W-1:0]  src_segment;
    } t_in_item;

    typedef struct packed {
        logic [SEG_W-1:0] out_segment;
        logic             flood;
        logic             learned;
    } t_out_item;

    // seg: 0 = first segment, 1 = second segment
    typedef struct packed {
        logic              valid;
        logic              seg;
        logic [ADDR_W-1:0] addr;
    } t_entry;

    typedef struct packed {
        logic             src_hit;
        logic [IDX_W-1:0] src_idx;
        logic             free_hit;
        logic [IDX_W-1:0] free_idx;
        logic             dst_hit;
        logic [IDX_W-1:0] dst_idx;
        logic             dst_seg;
    } t_match;

endpackage

`default_nettype wire

// ----- hw/rtl/learning_bridge_forward_top.sv -----
`default_nettype none

// Two-segment learning bridge. Each transfer on the input carries one frame header;
// each produces exactly one transfer on the output: the target segment, a flood flag
// and whether the source was learned. The address table is a single-port memory of
// TABLE_ENTRIES entries, scanned one entry per cycle with source and destination
// compared together. An accepted item passes through the scan, a compare of the last
// read and an update step (S_SCAN, S_DRAIN, S_FINISH) before its result is presented,
// and the block returns to idle before the next item is taken, so no new item is
// accepted while one is in progress. A result still stalled on the output holds the
// update step until it leaves. After reset a clearing pass writes every entry; no
// input is accepted during it. A full table is refilled round-robin.
module learning_bridge_forward_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  lbf_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output lbf_pkg::t_out_item o_out_data
);
    import lbf_pkg::*;

    typedef enum logic [4:0] {
        S_CLEAR  = 5'b00001,
        S_IDLE   = 5'b00010,
        S_SCAN   = 5'b00100,
        S_DRAIN  = 5'b01000,
        S_FINISH = 5'b10000
    } t_state;

    t_state           r_state;
    t_state           n_state;
    logic [IDX_W-1:0] r_cnt;
    logic [IDX_W-1:0] r_repl;
    t_in_item         r_item;
    t_entry           r_table [TABLE_ENTRIES];
    t_entry           r_rd_word;
    logic [IDX_W-1:0] r_rd_idx;
    logic             r_rd_vld;
    logic             r_out_valid;
    t_out_item        r_out_data;
    t_match           match;

    logic             in_xfer;
    logic             finish_go;
    logic [SEG_W-1:0] seg_norm;
    logic             learn;
    logic             table_full;
    logic [IDX_W-1:0] slot;
    logic [SEG_W-1:0] dest_seg;
    logic             flood;
    t_out_item        result;

    assign o_in_stall = (r_state != S_IDLE);
    assign in_xfer    = i_in_valid && !o_in_stall;
    assign finish_go  = (r_state == S_FINISH) && (!r_out_valid || !i_out_stall);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR:  if (r_cnt == LAST_IDX) n_state = S_IDLE;
            S_IDLE:   if (in_xfer) n_state = S_SCAN;
            S_SCAN:   if (r_cnt == LAST_IDX) n_state = S_DRAIN;
            S_DRAIN:  n_state = S_FINISH;
            S_FINISH: if (finish_go) n_state = S_IDLE;
            default:  n_state = S_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_cnt       <= '0;
            r_repl      <= '0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= (r_state == S_SCAN);
            if (r_state == S_CLEAR || r_state == S_SCAN) begin
                r_cnt <= (r_cnt == LAST_IDX) ? '0 : r_cnt + 1'b1;
            end
            if (finish_go && learn && table_full) begin
                r_repl <= (r_repl == LAST_IDX) ? '0 : r_repl + 1'b1;
            end
            if (finish_go) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_item <= i_in_data;
        end
        if (finish_go) begin
            r_out_data <= result;
        end
        r_rd_idx <= r_cnt;
    end

    // table memory: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (r_state == S_CLEAR) begin
            r_table[r_cnt] <= '0;
        end else if (finish_go && learn) begin
            r_table[slot] <= '{valid: 1'b1, seg: (seg_norm == SEG_SECOND), addr: r_item.src_mac};
        end
        if (r_state == S_SCAN) begin
            r_rd_word <= r_table[r_cnt];
        end
    end

    lbf_match u_match (
        .i_clk     (i_clk),
        .i_clear   (in_xfer),
        .i_rd_vld  (r_rd_vld),
        .i_rd_idx  (r_rd_idx),
        .i_rd_word (r_rd_word),
        .i_src_mac (r_item.src_mac),
        .i_dst_mac (r_item.dst_mac),
        .o_match   (match)
    );

    always_comb begin
        seg_norm   = (r_item.src_segment == SEG_INVALID) ? SEG_NONE : r_item.src_segment;
        learn      = (seg_norm != SEG_NONE);
        table_full = !match.src_hit && !match.free_hit;
        if (match.src_hit) begin
            slot = match.src_idx;
        end else if (match.free_hit) begin
            slot = match.free_idx;
        end else begin
            slot = r_repl;
        end

        // destination sees the table after this item's write
        if (learn && (r_item.dst_mac == r_item.src_mac)) begin
            dest_seg = seg_norm;
        end else if (match.dst_hit && !(learn && (slot == match.dst_idx))) begin
            dest_seg = match.dst_seg ? SEG_SECOND : SEG_FIRST;
        end else begin
            dest_seg = SEG_NONE;
        end

        flood = (dest_seg == SEG_NONE) || (dest_seg == seg_norm);
        result.flood       = flood;
        result.learned     = learn;
        result.out_segment = flood ? ((seg_norm == SEG_FIRST) ? SEG_SECOND : SEG_FIRST)
                                   : dest_seg;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    a_accept_starts_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> (r_state == S_SCAN) && (r_cnt == '0))
        else $error("scan did not start at first entry");

    a_finish_loads_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        finish_go |=> o_out_valid && (r_state == S_IDLE))
        else $error("result not loaded on finish");

    a_out_segment_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.out_segment == SEG_FIRST ||
                         o_out_data.out_segment == SEG_SECOND))
        else $error("illegal output segment");

    a_repl_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_CLEAR) && !$stable(r_repl) |-> $past(finish_go && learn && table_full))
        else $error("replace pointer moved without replacement");

endmodule

`default_nettype wire

// ----- hw/rtl/lbf_match.sv -----
`default_nettype none

module lbf_match (
    input  logic                       i_clk,
    input  logic                       i_clear,
    input  logic                       i_rd_vld,
    input  logic [lbf_pkg::IDX_W-1:0]  i_rd_idx,
    input  lbf_pkg::t_entry            i_rd_word,
    input  logic [lbf_pkg::ADDR_W-1:0] i_src_mac,
    input  logic [lbf_pkg::ADDR_W-1:0] i_dst_mac,
    output lbf_pkg::t_match            o_match
);
    import lbf_pkg::*;

    t_match r_match;
    t_match n_match;
    logic   src_eq;
    logic   dst_eq;

    assign src_eq = i_rd_word.valid && (i_rd_word.addr == i_src_mac);
    assign dst_eq = i_rd_word.valid && (i_rd_word.addr == i_dst_mac);

    always_comb begin
        n_match = r_match;
        if (i_clear) begin
            n_match.src_hit  = 1'b0;
            n_match.free_hit = 1'b0;
            n_match.dst_hit  = 1'b0;
        end else if (i_rd_vld) begin
            if (!r_match.src_hit && src_eq) begin
                n_match.src_hit = 1'b1;
                n_match.src_idx = i_rd_idx;
            end
            if (!r_match.free_hit && !i_rd_word.valid) begin
                n_match.free_hit = 1'b1;
                n_match.free_idx = i_rd_idx;
            end
            if (!r_match.dst_hit && dst_eq) begin
                n_match.dst_hit = 1'b1;
                n_match.dst_idx = i_rd_idx;
                n_match.dst_seg = i_rd_word.seg;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_match <= n_match;
    end

    assign o_match = r_match;

endmodule

`default_nettype wire

// ----- tb/sv/lbf_forward_checker.sv -----
`timescale 1ns / 100ps

module lbf_forward_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  lbf_pkg::t_in_item  i_in_data,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  lbf_pkg::t_out_item i_out_data,
    output int                 o_pending,
    output int                 o_fail_count
);
    import lbf_pkg::*;

    logic [ADDR_W-1:0] station_addr [TABLE_ENTRIES];
    logic              station_seg  [TABLE_ENTRIES];
    logic              station_valid[TABLE_ENTRIES];
    int unsigned       victim_idx;

    t_out_item         forward_q[$];

    initial begin
        o_pending    = 0;
        o_fail_count = 0;
    end

    task automatic report_mismatch(input string what);
        $display("tb: mismatch at %0t: %s", $realtime, what);
        o_fail_count++;
    endtask

    function automatic int lookup_station(input logic [ADDR_W-1:0] mac);
        for (int k = 0; k < TABLE_ENTRIES; k++) begin
            if (station_valid[k] && station_addr[k] == mac) begin
                return k;
            end
        end
        return -1;
    endfunction

    function automatic t_out_item forward_frame(input t_in_item frame);
        logic [SEG_W-1:0] seg;
        logic [SEG_W-1:0] dst_seg;
        int               slot;
        t_out_item        res;
        seg = frame.src_segment;
        if (seg == SEG_INVALID) begin
            seg = SEG_NONE;
        end
        res.learned = 1'b0;
        if (seg != SEG_NONE) begin
            slot = lookup_station(frame.src_mac);
            for (int k = 0; k < TABLE_ENTRIES && slot < 0; k++) begin
                if (!station_valid[k]) begin
                    slot = k;
                end
            end
            if (slot < 0) begin
                slot       = victim_idx;
                victim_idx = (victim_idx + 1) % TABLE_ENTRIES;
            end
            station_addr[slot]  = frame.src_mac;
            station_seg[slot]   = (seg == SEG_SECOND);
            station_valid[slot] = 1'b1;
            res.learned         = 1'b1;
        end
        slot    = lookup_station(frame.dst_mac);
        dst_seg = SEG_NONE;
        if (slot >= 0) begin
            dst_seg = station_seg[slot] ? SEG_SECOND : SEG_FIRST;
        end
        if (dst_seg == SEG_NONE || dst_seg == seg) begin
            res.flood       = 1'b1;
            res.out_segment = (seg == SEG_FIRST) ? SEG_SECOND : SEG_FIRST;
        end else begin
            res.flood       = 1'b0;
            res.out_segment = dst_seg;
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            for (int k = 0; k < TABLE_ENTRIES; k++) begin
                station_addr[k]  = '0;
                station_seg[k]   = 1'b0;
                station_valid[k] = 1'b0;
            end
            victim_idx = 0;
            forward_q.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (forward_q.size() == 0) begin
                    report_mismatch("result transfer with no frame outstanding");
                end else begin
                    want = forward_q.pop_front();
                    if (i_out_data.out_segment !== want.out_segment) begin
                        report_mismatch($sformatf("out_segment got %0d want %0d",
                                                  i_out_data.out_segment, want.out_segment));
                    end
                    if (i_out_data.flood !== want.flood) begin
                        report_mismatch($sformatf("flood got %0b want %0b",
                                                  i_out_data.flood, want.flood));
                    end
                    if (i_out_data.learned !== want.learned) begin
                        report_mismatch($sformatf("learned got %0b want %0b",
                                                  i_out_data.learned, want.learned));
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                forward_q.insert(forward_q.size(), forward_frame(i_in_data));
            end
        end
        o_pending <= forward_q.size();
    end

endmodule

// ----- tb/sv/tb_learning_bridge_forward_top.sv -----
`timescale 1ns / 100ps

module tb_learning_bridge_forward_top;
    import lbf_pkg::*;

    localparam int POOL_SIZE     = 48;
    localparam int RANDOM_FRAMES = 730;
    localparam int HOLD_CYCLES   = 400;
    localparam int IDLE_LIMIT    = 4000;
    localparam int DRAIN_CYCLES  = 40;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_stall;
    t_in_item  in_data   = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_item out_data;

    int          pending;
    int          fail_count;
    int          results_seen = 0;
    int          idle_cycles  = 0;
    int unsigned burst_left   = 0;

    logic [ADDR_W-1:0] stations[POOL_SIZE];

    learning_bridge_forward_top i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    lbf_forward_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_data   (out_data),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    initial begin
        forever #6 clk = ~clk;
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            results_seen <= results_seen + 1;
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic logic [ADDR_W-1:0] random_mac();
        logic [63:0] wide;
        wide = {$urandom, $urandom};
        return wide[ADDR_W-1:0];
    endfunction

    function automatic t_in_item make_frame(input logic [ADDR_W-1:0] src,
                                            input logic [ADDR_W-1:0] dst,
                                            input logic [SEG_W-1:0]  seg);
        t_in_item f;
        f.src_mac     = src;
        f.dst_mac     = dst;
        f.src_segment = seg;
        return f;
    endfunction

    function automatic t_in_item random_frame();
        t_in_item    f;
        int unsigned pick;
        if ($urandom_range(0, 99) < 85) begin
            f.src_mac = stations[$urandom_range(0, POOL_SIZE - 1)];
        end else begin
            f.src_mac = random_mac();
        end
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
            f.dst_mac = f.src_mac;
        end else if (pick < 20) begin
            f.dst_mac = random_mac();
        end else begin
            f.dst_mac = stations[$urandom_range(0, POOL_SIZE - 1)];
        end
        pick = $urandom_range(0, 99);
        if (pick < 12) begin
            f.src_segment = SEG_NONE;
        end else if (pick < 20) begin
            f.src_segment = SEG_INVALID;
        end else if (pick < 60) begin
            f.src_segment = SEG_FIRST;
        end else begin
            f.src_segment = SEG_SECOND;
        end
        return f;
    endfunction

    task automatic offer_frame(input t_in_item frame);
        int unsigned gap;
        in_valid <= 1'b1;
        in_data  <= frame;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 10);
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                              : $urandom_range(0, 4);
            if (gap != 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end else begin
            burst_left--;
        end
    endtask

    task automatic await_results();
        in_valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
    endtask

    initial begin : result_sink
        bit held;
        held = 1'b0;
        @(posedge clk);
        forever begin
            if (!held && results_seen >= 200) begin
                held = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            case ($urandom_range(0, 3))
                0: begin
                    out_stall <= 1'b0;
                    repeat ($urandom_range(10, 150)) @(posedge clk);
                end
                1: begin
                    repeat ($urandom_range(10, 120)) begin
                        out_stall <= ($urandom_range(0, 99) < 40);
                        @(posedge clk);
                    end
                end
                2: begin
                    out_stall <= 1'b1;
                    repeat ($urandom_range(1, 60)) @(posedge clk);
                end
                default: begin
                    repeat ($urandom_range(4, 40)) begin
                        out_stall <= 1'($urandom_range(0, 1));
                        @(posedge clk);
                    end
                end
            endcase
        end
    end

    initial begin : frame_source
        logic [ADDR_W-1:0] sta_a;
        logic [ADDR_W-1:0] sta_b;
        logic [ADDR_W-1:0] sta_c;
        logic [ADDR_W-1:0] zeros;
        logic [ADDR_W-1:0] ones;
        sta_a = 48'h0002_1a2b_3c4d;
        sta_b = 48'h00a0_5e00_0b01;
        sta_c = 48'h7ffe_dc00_1234;
        zeros = '0;
        ones  = '1;
        stations[0] = zeros;
        stations[1] = ones;
        for (int k = 2; k < POOL_SIZE; k++) begin
            stations[k] = random_mac();
        end
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        offer_frame(make_frame(sta_a, sta_b, SEG_NONE));
        offer_frame(make_frame(sta_a, sta_b, SEG_INVALID));
        offer_frame(make_frame(sta_a, sta_b, SEG_FIRST));
        offer_frame(make_frame(sta_b, sta_a, SEG_SECOND));
        offer_frame(make_frame(sta_a, sta_b, SEG_FIRST));
        offer_frame(make_frame(sta_c, sta_a, SEG_FIRST));
        offer_frame(make_frame(sta_a, sta_a, SEG_SECOND));
        offer_frame(make_frame(sta_b, sta_a, SEG_SECOND));
        offer_frame(make_frame(sta_c, sta_a, SEG_NONE));
        offer_frame(make_frame(sta_c, sta_c, SEG_NONE));
        offer_frame(make_frame(sta_c, sta_b, SEG_INVALID));
        offer_frame(make_frame(sta_b, sta_b, SEG_SECOND));
        offer_frame(make_frame(zeros, ones, SEG_FIRST));
        offer_frame(make_frame(ones, zeros, SEG_SECOND));
        offer_frame(make_frame(zeros, ones, SEG_FIRST));
        offer_frame(make_frame(ones, ones, SEG_FIRST));
        offer_frame(make_frame(zeros, ones, SEG_SECOND));
        offer_frame(make_frame(ones, zeros, SEG_INVALID));
        offer_frame(make_frame(zeros, zeros, SEG_NONE));
        await_results();

        for (int n = 0; n < RANDOM_FRAMES; n++) begin
            if (n == RANDOM_FRAMES / 2) begin
                await_results();
            end
            offer_frame(random_frame());
        end
        await_results();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
